// File: src/dlr_pkg.sv
// ----------------------------------------------------------------------------
// dlr_pkg
// shared types and constants of the dense layer with relu
// ----------------------------------------------------------------------------
`default_nettype none

package dlr_pkg;

	localparam int IN_SIZE_DEF  = 64;
	localparam int OUT_SIZE_DEF = 64;

	localparam int IDX_W   = 6;
	localparam int VAL_W   = 16;
	localparam int PROD_W  = 2 * VAL_W;
	localparam int ACT_W   = 15;
	localparam int FRAC_W  = 8;
	localparam int ACC_W   = 40;
	localparam int WADDR_W = 2 * IDX_W;

	localparam logic [1:0] MODE_WEIGHT = 2'd0;
	localparam logic [1:0] MODE_BIAS   = 2'd1;
	localparam logic [1:0] MODE_INPUT  = 2'd2;

	typedef struct packed {
		logic init;
		logic mul_v;
	} mac_ctrl_t;

endpackage

`default_nettype wire

// File: src/dlr_mac.sv
// ----------------------------------------------------------------------------
// dlr_mac
// shared multiply-accumulate unit with rounding, relu and saturation
// ----------------------------------------------------------------------------
`default_nettype none

module dlr_mac (
	input  wire                               clk,
	input  wire                               arst_n,
	input  dlr_pkg::mac_ctrl_t                ctrl,
	input  wire signed [dlr_pkg::VAL_W-1:0]   bias,
	input  wire signed [dlr_pkg::VAL_W-1:0]   x,
	input  wire signed [dlr_pkg::VAL_W-1:0]   w,
	output logic                              busy,
	output logic       [dlr_pkg::ACT_W-1:0]   act
);

	logic signed [dlr_pkg::PROD_W-1:0] prod_s2;
	logic                              mul_v_s2;
	logic signed [dlr_pkg::ACC_W-1:0]  acc_q;
	logic signed [dlr_pkg::ACC_W-1:0]  rnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_v_s2 <= 1'b0;
		end else begin
			mul_v_s2 <= ctrl.mul_v;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul_v) begin
			prod_s2 <= x * w;
		end
		if (ctrl.init) begin
			acc_q <= {{(dlr_pkg::ACC_W-dlr_pkg::VAL_W-dlr_pkg::FRAC_W){bias[dlr_pkg::VAL_W-1]}},
				bias, {dlr_pkg::FRAC_W{1'b0}}};
		end else if (mul_v_s2) begin
			acc_q <= acc_q + {{(dlr_pkg::ACC_W-dlr_pkg::PROD_W){prod_s2[dlr_pkg::PROD_W-1]}},
				prod_s2};
		end
	end

	assign busy = mul_v_s2;

	// round half up, then clamp to 0..32767
	always_comb begin
		rnd = acc_q + dlr_pkg::ACC_W'(128);
		if (rnd[dlr_pkg::ACC_W-1]) begin
			act = '0;
		end else if (rnd[dlr_pkg::ACC_W-2:dlr_pkg::ACT_W+dlr_pkg::FRAC_W] != '0) begin
			act = '1;
		end else begin
			act = rnd[dlr_pkg::ACT_W+dlr_pkg::FRAC_W-1:dlr_pkg::FRAC_W];
		end
	end

endmodule

`default_nettype wire

// File: src/dense_layer_relu_unit.sv
// ----------------------------------------------------------------------------
// dense_layer_relu_unit
// fully connected layer with relu, signed q8.8, one shared mac unit
// ----------------------------------------------------------------------------
// Input words with tuser 0 load a weight, 1 load a bias, 2 load an input
// element. An input element with tlast set starts the layer: for every
// neuron one output word is produced, in neuron order, with tlast on the
// last neuron. A single multiply-accumulate unit walks the weight memory
// one product per cycle; tready stays low while a run is in progress.
// Weights, biases and inputs must be written before they are used.
`default_nettype none

module dense_layer_relu_unit #(
	parameter int IN_SIZE  = dlr_pkg::IN_SIZE_DEF,
	parameter int OUT_SIZE = dlr_pkg::OUT_SIZE_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [31:0] s_axis_tdata,  // row[5:0], col[11:6], value[27:12], zero pad
	input  wire  [1:0]  s_axis_tuser,  // mode[1:0]
	input  wire         s_axis_tlast,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [23:0] m_axis_tdata,  // neuron[5:0], activation[20:6], zero pad
	output logic        m_axis_tlast
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_BIAS  = 5'b00010,
		ST_MAC   = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	localparam int NSTORE = 1 << dlr_pkg::IDX_W;

	state_t                          state_q;
	logic [dlr_pkg::IDX_W-1:0]       o_q;
	logic [dlr_pkg::IDX_W-1:0]       i_q;
	logic                            rd_v_s1;
	logic signed [dlr_pkg::VAL_W-1:0] w_rd_s1;
	logic signed [dlr_pkg::VAL_W-1:0] x_rd_s1;
	logic signed [dlr_pkg::VAL_W-1:0] bias_rd_q;
	logic                            out_v_q;
	logic [dlr_pkg::IDX_W-1:0]       out_neuron_q;
	logic [dlr_pkg::ACT_W-1:0]       out_act_q;
	logic                            out_last_q;

	logic [dlr_pkg::VAL_W-1:0] weight_mem [NSTORE*NSTORE];
	logic [dlr_pkg::VAL_W-1:0] bias_mem   [NSTORE];
	logic [dlr_pkg::VAL_W-1:0] input_mem  [NSTORE];

	logic [1:0]                in_mode;
	logic [dlr_pkg::IDX_W-1:0] in_row;
	logic [dlr_pkg::IDX_W-1:0] in_col;
	logic [dlr_pkg::VAL_W-1:0] in_value;
	logic                      in_acc;
	logic                      row_ok;
	logic                      col_ok;
	logic                      mac_busy;
	logic [dlr_pkg::ACT_W-1:0] mac_act;
	logic                      out_load;
	dlr_pkg::mac_ctrl_t        mac_ctrl;

	assign in_mode  = s_axis_tuser;
	assign in_row   = s_axis_tdata[5:0];
	assign in_col   = s_axis_tdata[11:6];
	assign in_value = s_axis_tdata[27:12];
	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign row_ok   = {1'b0, in_row} < 7'(OUT_SIZE);
	assign col_ok   = {1'b0, in_col} < 7'(IN_SIZE);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign out_load      = (state_q == ST_EMIT) && (!out_v_q || m_axis_tready);

	assign mac_ctrl.init  = (state_q == ST_MAC) && (i_q == '0);
	assign mac_ctrl.mul_v = rd_v_s1;

	// memories
	always_ff @(posedge clk) begin
		if (in_acc && in_mode == dlr_pkg::MODE_WEIGHT && row_ok && col_ok) begin
			weight_mem[{in_row, in_col}] <= in_value;
		end
		if (in_acc && in_mode == dlr_pkg::MODE_BIAS && row_ok) begin
			bias_mem[in_row] <= in_value;
		end
		if (in_acc && in_mode == dlr_pkg::MODE_INPUT && col_ok) begin
			input_mem[in_col] <= in_value;
		end
		if (state_q == ST_MAC) begin
			w_rd_s1 <= weight_mem[{o_q, i_q}];
			x_rd_s1 <= input_mem[i_q];
		end
		if (state_q == ST_BIAS) begin
			bias_rd_q <= bias_mem[o_q];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			o_q     <= '0;
			i_q     <= '0;
			rd_v_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == ST_MAC);
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && in_mode == dlr_pkg::MODE_INPUT && s_axis_tlast) begin
						o_q     <= '0;
						state_q <= ST_BIAS;
					end
				end
				ST_BIAS: begin
					i_q     <= '0;
					state_q <= ST_MAC;
				end
				ST_MAC: begin
					i_q <= i_q + dlr_pkg::IDX_W'(1);
					if (i_q == dlr_pkg::IDX_W'(IN_SIZE - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!rd_v_s1 && !mac_busy) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						if (o_q == dlr_pkg::IDX_W'(OUT_SIZE - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							o_q     <= o_q + dlr_pkg::IDX_W'(1);
							state_q <= ST_BIAS;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_neuron_q <= o_q;
			out_act_q    <= mac_act;
			out_last_q   <= (o_q == dlr_pkg::IDX_W'(OUT_SIZE - 1));
		end
	end

	dlr_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.bias   (bias_rd_q),
		.x      (x_rd_s1),
		.w      (w_rd_s1),
		.busy   (mac_busy),
		.act    (mac_act)
	);

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {3'b000, out_act_q, out_neuron_q};
	assign m_axis_tlast  = out_last_q;

`ifndef ASSERT_OFF
	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!rd_v_s1 && !mac_busy))
		else $error("mac pipeline busy while idle");

	a_last_neuron: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (out_neuron_q == dlr_pkg::IDX_W'(OUT_SIZE - 1)))
		else $error("tlast on a neuron other than the last");

	a_init_after_bias: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC && i_q == '0) |-> ($past(state_q) == ST_BIAS))
		else $error("accumulator init without a bias read");

	a_emit_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> ($past(state_q) == ST_EMIT))
		else $error("output word loaded outside the emit step");
`endif

endmodule

`default_nettype wire
